### sv/ffbta_pkg.sv
// Shared constants, codes and helpers of the first-fit boundary-tag heap allocator.
package ffbta_pkg;

  localparam int HEAP_WORDS = 4096;
  localparam int AW         = $clog2(HEAP_WORDS);
  localparam int DW         = 16;
  localparam int SW         = AW + 1;
  localparam int NW         = 14;
  localparam int CW         = 15;
  localparam int TW         = 32;
  localparam int LW         = 13;

  localparam logic [LW-1:0] LIMIT_RESET = LW'(2048);
  localparam logic [CW-1:0] COUNT_MAX   = {CW{1'b1}};
  localparam logic [AW-1:0] FIRST_FREE  = AW'(2);
  localparam logic [SW-1:0] FIRST_SIZE  = SW'(HEAP_WORDS - 4);
  localparam logic [SW-1:0] MIN_SPLIT   = SW'(4);
  localparam logic [NW-1:0] MIN_NEED    = NW'(4);
  localparam logic [AW-1:0] TOP_SENT    = AW'(HEAP_WORDS - 2);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_NOT_TKN = 2'd2,
    ST_NULL    = 2'd3
  } status_e;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Magnitude of a boundary tag.
  function automatic logic [SW-1:0] tag_mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] a;
    a = v[DW-1] ? DW'(-v) : DW'(v);
    return a[SW-1:0];
  endfunction

  // Tag of a taken block of n words.
  function automatic logic [DW-1:0] neg_tag(input logic [SW-1:0] n);
    return DW'(-{{(DW-SW){1'b0}}, n});
  endfunction

endpackage

### sv/first_fit_boundary_tag_allocator.sv
// Top level of the first-fit boundary-tag heap allocator with its heap memory and sequencer.
//
// This block manages a heap of HEAP_WORDS 16-bit words held in one single-port memory.
// Every block has its size in words in its header and footer word, negative while taken;
// free blocks form a LIFO doubly linked list (next in word 1, previous in word 2). An
// allocate transfer on the slave stream (tuser = 0) takes the first free block on the list
// that holds ceil(bytes/4)+2 words (at least 4), giving up at the first block at or above
// search_limit, and splits it when 4 or more words remain; a free transfer (tuser = 1)
// checks that the address names a taken block, merges it with free neighbors and pushes
// it. Each request yields exactly one result transfer on the master stream. After reset
// the sequencer writes the two sentinels and the initial free block before it accepts the
// first request. All work goes through the one memory port, one read or write per cycle:
// an allocate reads each free block it skips on the list, then unlinks, marks and splits
// the block taken and pushes the rest; a free walks the blocks from the bottom of the heap
// to validate the address, then merges and pushes. A null or out-of-range free and a
// zero-byte allocate go straight to the result. The next request is accepted while a
// finished result still waits in the output register. search_limit is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while idle, not enforced by the block.
module first_fit_boundary_tag_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [14:0] request_bytes, [26:15] free_address, [31:27] zero
  input  logic [31:0] s_axis_tdata,
  // [0] operation
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [11:0] data_address, [26:12] bytes_in_use, [58:27] bytes_allocated_total, [63:59] zero
  output logic [63:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);
  import ffbta_pkg::*;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_A_CHK, S_A_SZ, S_A_NXT, S_A_SPLIT, S_M_H, S_M_F,
    S_U_RN, S_U_RP, S_U_W1, S_U_W2,
    S_P_H, S_P_F, S_P_N, S_P_P, S_P_L,
    S_B_CHK, S_B_RD, S_F_RD, S_F_TAG, S_F_LM, S_F_LT, S_F_R, S_F_RT, S_F_PUSH,
    S_FIN
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;

  logic [LW-1:0] limit_q;
  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] inuse_q, inuse_d;
  logic [TW-1:0] alloc_q, alloc_d;
  logic [2:0]    init_q, init_d;

  logic [AW-1:0] p_q, p_d, u_q, u_d, nxt_q, nxt_d, prv_q, prv_d, idx_q, idx_d;
  logic [AW-1:0] start_q, start_d;
  logic [SW-1:0] sz_q, sz_d, total_q, total_d, walk_q, walk_d;
  logic [NW-1:0] need_q, need_d;
  logic          split_q, split_d;
  status_e       res_st_q, res_st_d;
  logic [AW-1:0] res_addr_q, res_addr_d;

  logic          out_valid_q;
  status_e       out_st_q;
  logic [AW-1:0] out_addr_q;
  logic [CW-1:0] out_inuse_q;
  logic [TW-1:0] out_alloc_q;

  // Heap memory, one port, registered read data.
  logic [DW-1:0]        heap_q [HEAP_WORDS];
  logic signed [DW-1:0] rdata_q;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [DW-1:0]        mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      heap_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= heap_q[mem_addr];
  end

  logic [SW-1:0]   rmag;
  logic [CW+1:0]   add_sum;
  logic [CW-1:0]   add4;
  logic [CW-1:0]   sub4;
  logic [NW-1:0]   need_c;
  logic [SW-1:0]   rem;
  logic            out_free;
  logic            accept;

  assign rmag     = tag_mag(rdata_q);
  assign add4     = CW'({need_q, 2'b00});
  assign add_sum  = (CW+2)'(inuse_q) + (CW+2)'({need_q, 2'b00});
  assign sub4     = CW'({rmag, 2'b00});
  assign need_c   = NW'(({1'b0, s_axis_tdata[14:0]} + 16'd3) >> 2) + NW'(2);
  assign rem      = sz_q - SW'(need_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    head_d     = head_q;
    inuse_d    = inuse_q;
    alloc_d    = alloc_q;
    init_d     = init_q;
    p_d        = p_q;
    u_d        = u_q;
    nxt_d      = nxt_q;
    prv_d      = prv_q;
    idx_d      = idx_q;
    start_d    = start_q;
    sz_d       = sz_q;
    total_d    = total_q;
    walk_d     = walk_q;
    need_d     = need_q;
    split_d    = split_q;
    res_st_d   = res_st_q;
    res_addr_d = res_addr_q;
    mem_we     = 1'b0;
    mem_addr   = '0;
    mem_wdata  = '0;

    case (state_q)
      S_INIT: begin
        // Lay down the bottom sentinel, the one free block and the top sentinel.
        mem_we = 1'b1;
        init_d = init_q + 3'd1;
        case (init_q)
          3'd0: begin mem_addr = AW'(0); mem_wdata = neg_tag(SW'(2)); end
          3'd1: begin mem_addr = AW'(1); mem_wdata = neg_tag(SW'(2)); end
          3'd2: begin mem_addr = FIRST_FREE; mem_wdata = DW'(FIRST_SIZE); end
          3'd3: begin mem_addr = FIRST_FREE + AW'(1); mem_wdata = '0; end
          3'd4: begin mem_addr = FIRST_FREE + AW'(2); mem_wdata = '0; end
          3'd5: begin mem_addr = TOP_SENT - AW'(1); mem_wdata = DW'(FIRST_SIZE); end
          3'd6: begin mem_addr = TOP_SENT; mem_wdata = neg_tag(SW'(2)); end
          default: begin
            mem_addr  = TOP_SENT + AW'(1);
            mem_wdata = neg_tag(SW'(2));
            state_d   = S_IDLE;
          end
        endcase
      end

      S_IDLE: begin
        if (accept) begin
          res_st_d   = ST_OK;
          res_addr_d = '0;
          ret_d      = S_FIN;
          if (s_axis_tuser == OP_ALLOC) begin
            need_d = (need_c < MIN_NEED) ? MIN_NEED : need_c;
            p_d    = head_q;
            state_d = (s_axis_tdata[14:0] == '0) ? S_FIN : S_A_CHK;
          end else begin
            idx_d  = s_axis_tdata[26:15] - AW'(1);
            walk_d = '0;
            if (s_axis_tdata[26:15] == '0) begin
              res_st_d = ST_NULL;
              state_d  = S_FIN;
            end else if ((s_axis_tdata[26:15] - AW'(1)) < AW'(2) ||
                         (s_axis_tdata[26:15] - AW'(1)) >= TOP_SENT) begin
              res_st_d = ST_NOT_TKN;
              state_d  = S_FIN;
            end else begin
              state_d = S_B_CHK;
            end
          end
        end
      end

      S_A_CHK: begin
        if (p_q == '0 || LW'(p_q) >= limit_q) begin
          res_st_d = ST_NO_MEM;
          state_d  = S_FIN;
        end else begin
          mem_addr = p_q;
          state_d  = S_A_SZ;
        end
      end
      S_A_SZ: begin
        sz_d = rmag;
        if (NW'(rmag) >= need_q) begin
          u_d     = p_q;
          ret_d   = S_A_SPLIT;
          state_d = S_U_RN;
        end else begin
          mem_addr = p_q + AW'(1);
          state_d  = S_A_NXT;
        end
      end
      S_A_NXT: begin
        p_d     = rdata_q[AW-1:0];
        state_d = S_A_CHK;
      end
      S_A_SPLIT: begin
        // The rest is split off only when it can hold a free block.
        split_d = (rem >= MIN_SPLIT);
        if (rem >= MIN_SPLIT) begin
          sz_d    = SW'(need_q);
          start_d = p_q + AW'(need_q);
          total_d = rem;
        end
        inuse_d    = (add_sum > (CW+2)'(COUNT_MAX)) ? COUNT_MAX : add_sum[CW-1:0];
        alloc_d    = alloc_q + TW'(add4);
        res_addr_d = p_q + AW'(1);
        ret_d      = S_FIN;
        state_d    = S_M_H;
      end
      S_M_H: begin
        mem_we    = 1'b1;
        mem_addr  = p_q;
        mem_wdata = neg_tag(sz_q);
        state_d   = S_M_F;
      end
      S_M_F: begin
        mem_we    = 1'b1;
        mem_addr  = p_q + AW'(sz_q) - AW'(1);
        mem_wdata = neg_tag(sz_q);
        state_d   = split_q ? S_P_H : S_FIN;
      end

      // Unlink block u_q from the free list, then continue at ret_q.
      S_U_RN: begin
        mem_addr = u_q + AW'(1);
        state_d  = S_U_RP;
      end
      S_U_RP: begin
        nxt_d    = rdata_q[AW-1:0];
        mem_addr = u_q + AW'(2);
        state_d  = S_U_W1;
      end
      S_U_W1: begin
        prv_d = rdata_q[AW-1:0];
        if (rdata_q[AW-1:0] == '0) begin
          head_d = nxt_q;
        end else begin
          mem_we    = 1'b1;
          mem_addr  = rdata_q[AW-1:0] + AW'(1);
          mem_wdata = DW'(nxt_q);
        end
        state_d = S_U_W2;
      end
      S_U_W2: begin
        if (nxt_q != '0) begin
          mem_we    = 1'b1;
          mem_addr  = nxt_q + AW'(2);
          mem_wdata = DW'(prv_q);
        end
        state_d = ret_q;
      end

      // Push block start_q of total_q words at the list head.
      S_P_H: begin
        mem_we    = 1'b1;
        mem_addr  = start_q;
        mem_wdata = DW'(total_q);
        state_d   = S_P_F;
      end
      S_P_F: begin
        mem_we    = 1'b1;
        mem_addr  = start_q + AW'(total_q) - AW'(1);
        mem_wdata = DW'(total_q);
        state_d   = S_P_N;
      end
      S_P_N: begin
        mem_we    = 1'b1;
        mem_addr  = start_q + AW'(1);
        mem_wdata = DW'(head_q);
        state_d   = S_P_P;
      end
      S_P_P: begin
        mem_we    = 1'b1;
        mem_addr  = start_q + AW'(2);
        mem_wdata = '0;
        state_d   = S_P_L;
      end
      S_P_L: begin
        if (head_q != '0) begin
          mem_we    = 1'b1;
          mem_addr  = head_q + AW'(2);
          mem_wdata = DW'(start_q);
        end
        head_d  = start_q;
        state_d = S_FIN;
      end

      // Walk the block chain from word 0 to check that idx_q starts a block.
      S_B_CHK: begin
        if (walk_q == SW'(idx_q)) begin
          state_d = S_F_RD;
        end else if (walk_q >= SW'(HEAP_WORDS)) begin
          res_st_d = ST_NOT_TKN;
          state_d  = S_FIN;
        end else begin
          mem_addr = walk_q[AW-1:0];
          state_d  = S_B_RD;
        end
      end
      S_B_RD: begin
        if (rmag < SW'(2)) begin
          res_st_d = ST_NOT_TKN;
          state_d  = S_FIN;
        end else begin
          walk_d  = walk_q + rmag;
          state_d = S_B_CHK;
        end
      end
      S_F_RD: begin
        mem_addr = idx_q;
        state_d  = S_F_TAG;
      end
      S_F_TAG: begin
        if (!rdata_q[DW-1]) begin
          res_st_d = ST_NOT_TKN;
          state_d  = S_FIN;
        end else begin
          sz_d     = rmag;
          total_d  = rmag;
          start_d  = idx_q;
          inuse_d  = (inuse_q > sub4) ? inuse_q - sub4 : '0;
          mem_addr = idx_q - AW'(1);
          state_d  = S_F_LM;
        end
      end
      S_F_LM: begin
        if (rmag <= SW'(idx_q)) begin
          p_d      = idx_q - AW'(rmag);
          mem_addr = idx_q - AW'(rmag);
          state_d  = S_F_LT;
        end else begin
          state_d = S_F_R;
        end
      end
      S_F_LT: begin
        if (rdata_q > 0) begin
          total_d = total_q + rmag;
          start_d = p_q;
          u_d     = p_q;
          ret_d   = S_F_R;
          state_d = S_U_RN;
        end else begin
          state_d = S_F_R;
        end
      end
      S_F_R: begin
        mem_addr = idx_q + AW'(sz_q);
        state_d  = S_F_RT;
      end
      S_F_RT: begin
        if (rdata_q > 0) begin
          total_d = total_q + rmag;
          u_d     = idx_q + AW'(sz_q);
          ret_d   = S_F_PUSH;
          state_d = S_U_RN;
        end else begin
          state_d = S_F_PUSH;
        end
      end
      S_F_PUSH: begin
        state_d = S_P_H;
      end

      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ret_q       <= S_FIN;
      init_q      <= '0;
      limit_q     <= LIMIT_RESET;
      head_q      <= FIRST_FREE;
      inuse_q     <= '0;
      alloc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      init_q  <= init_d;
      head_q  <= head_d;
      inuse_q <= inuse_d;
      alloc_q <= alloc_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (state_q == S_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q        <= p_d;
    u_q        <= u_d;
    nxt_q      <= nxt_d;
    prv_q      <= prv_d;
    idx_q      <= idx_d;
    start_q    <= start_d;
    sz_q       <= sz_d;
    total_q    <= total_d;
    walk_q     <= walk_d;
    need_q     <= need_d;
    split_q    <= split_d;
    res_st_q   <= res_st_d;
    res_addr_q <= res_addr_d;
    if (state_q == S_FIN && out_free) begin
      out_st_q    <= res_st_q;
      out_addr_q  <= res_addr_q;
      out_inuse_q <= inuse_q;
      out_alloc_q <= alloc_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tdata  = {5'b0, out_alloc_q, out_inuse_q, out_addr_q};

endmodule
